// ===== rtl/vertex_project_to_viewport_macros.svh =====
// Assertion helpers for the top-level RTL file.
// Each use expands to one labeled concurrent assertion on clk, off while arst_n is low.
`ifndef VERTEX_PROJECT_TO_VIEWPORT_MACROS_SVH
`define VERTEX_PROJECT_TO_VIEWPORT_MACROS_SVH

// same-cycle implication
`define VPV_CHECK_NOW(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define VPV_CHECK_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/vpv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_pkg
// Shared types, constants and saturating helpers for the vertex projector.
// ----------------------------------------------------------------------------
package vpv_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// quotient bits produced by the divider, one per step
	localparam int DIV_STEPS = 63;

	localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
	localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;
	localparam logic signed [31:0] S32_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;

	typedef enum logic [2:0] {
		REG_LEFT   = 3'd0,
		REG_TOP    = 3'd1,
		REG_WIDTH  = 3'd2,
		REG_HEIGHT = 3'd3,
		REG_NEAR   = 3'd4,
		REG_FAR    = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic valid;
		logic w_zero;
	} ctl_t;

	typedef struct packed {
		logic signed [31:0] left;
		logic signed [31:0] top;
		logic [15:0]        width;
		logic [15:0]        height;
		logic [16:0]        near;
		logic [16:0]        far;
	} vp_cfg_t;

	function automatic logic signed [63:0] sat_add64(input logic signed [63:0] a,
		input logic signed [63:0] b);
		logic [64:0] s;
		s = {a[63], a} + {b[63], b};
		if (s[64] != s[63])
			return s[64] ? S64_MIN : S64_MAX;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] sat64(input logic signed [81:0] v);
		if (&v[81:63] || ~|v[81:63])
			return v[63:0];
		return v[81] ? S64_MIN : S64_MAX;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [64:0] v);
		if (&v[64:31] || ~|v[64:31])
			return v[31:0];
		return v[64] ? S32_MIN : S32_MAX;
	endfunction

endpackage

// ===== rtl/vpv_matmul.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_matmul
// Coefficient store and row-vector times 4x4 matrix, five stages deep.
// ----------------------------------------------------------------------------
module vpv_matmul #(
	parameter int FRAC_BITS = vpv_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                load,
	input  logic                proj,
	input  logic [3:0]          coef_index,
	input  logic signed [31:0]  coef_value,
	input  logic signed [31:0]  point_x,
	input  logic signed [31:0]  point_y,
	input  logic signed [31:0]  point_z,
	output vpv_pkg::ctl_t       ctl_out,
	output logic signed [63:0]  clip_x,
	output logic signed [63:0]  clip_y,
	output logic signed [63:0]  clip_z,
	output logic signed [63:0]  clip_w
);

	localparam logic signed [31:0] ONE_C = 32'sd1 <<< FRAC_BITS;

	logic signed [31:0] mat_q [16];

	logic               v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [31:0] pt_s1 [3];
	logic signed [63:0] prod_s2 [3][4];
	logic signed [63:0] bot_s2 [4];
	logic signed [63:0] acc_s3 [4];
	logic signed [63:0] p2_s3 [4];
	logic signed [63:0] bot_s3 [4];
	logic signed [63:0] acc_s4 [4];
	logic signed [63:0] bot_s4 [4];
	logic signed [63:0] clip_s5 [4];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 16; i++)
				mat_q[i] <= (i[3:2] == i[1:0]) ? ONE_C : '0;
		end else if (load) begin
			mat_q[coef_index] <= coef_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= proj;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// the matrix is read as the item leaves s1, after every earlier load
	always_ff @(posedge clk) begin
		if (en) begin
			pt_s1[0] <= point_x;
			pt_s1[1] <= point_y;
			pt_s1[2] <= point_z;
			for (int c = 0; c < 4; c++) begin
				for (int r = 0; r < 3; r++)
					prod_s2[r][c] <= 64'(pt_s1[r]) * 64'(mat_q[r * 4 + c]);
				bot_s2[c] <= {{32{mat_q[12 + c][31]}}, mat_q[12 + c]} << FRAC_BITS;
				acc_s3[c] <= vpv_pkg::sat_add64(prod_s2[0][c], prod_s2[1][c]);
				p2_s3[c] <= prod_s2[2][c];
				bot_s3[c] <= bot_s2[c];
				acc_s4[c] <= vpv_pkg::sat_add64(acc_s3[c], p2_s3[c]);
				bot_s4[c] <= bot_s3[c];
				clip_s5[c] <= vpv_pkg::sat_add64(acc_s4[c], bot_s4[c]);
			end
		end
	end

	assign clip_x = clip_s5[0];
	assign clip_y = clip_s5[1];
	assign clip_z = clip_s5[2];
	assign clip_w = clip_s5[3];
	assign ctl_out.valid  = v_s5;
	assign ctl_out.w_zero = (clip_s5[3] == '0);

endmodule

// ===== rtl/vpv_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_div
// Pipelined signed fixed-point divider: trunc(num * 2^FRAC_BITS / den),
// saturated. Magnitude stage, set-up stage, one restoring step per stage,
// then a sign stage.
// ----------------------------------------------------------------------------
module vpv_div #(
	parameter int FRAC_BITS = vpv_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  vpv_pkg::ctl_t      ctl_in,
	input  logic signed [63:0] num,
	input  logic signed [63:0] den,
	output vpv_pkg::ctl_t      ctl_out,
	output logic signed [63:0] quot
);

	localparam int NS = vpv_pkg::DIV_STEPS;

	vpv_pkg::ctl_t ctl_s1;
	logic          neg_s1;
	logic [63:0]   un_s1, ud_s1;
	logic [63:0]   top_part;

	vpv_pkg::ctl_t ctl_s [0:NS];
	logic          neg_s [0:NS];
	logic          ovf_s [0:NS];
	logic [63:0]   ud_s [0:NS];
	logic [63:0]   rem_s [0:NS];
	logic [NS-1:0] work_s [0:NS];

	vpv_pkg::ctl_t      ctl_sf;
	logic signed [63:0] quot_sf;
	logic signed [63:0] q_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1   <= '0;
			ctl_s[0] <= '0;
			ctl_sf   <= '0;
		end else if (en) begin
			ctl_s1   <= ctl_in;
			ctl_s[0] <= ctl_s1;
			ctl_sf   <= ctl_s[NS];
		end
	end

	assign top_part = un_s1 >> (63 - FRAC_BITS);
	assign q_full   = {1'b0, work_s[NS]};

	always_ff @(posedge clk) begin
		if (en) begin
			un_s1  <= num[63] ? 64'(-num) : num;
			ud_s1  <= den[63] ? 64'(-den) : den;
			neg_s1 <= num[63] ^ den[63];
			// integer part too large for the result: saturate
			ovf_s[0]  <= (top_part >= ud_s1);
			rem_s[0]  <= top_part;
			work_s[0] <= un_s1[62:0] << FRAC_BITS;
			ud_s[0]   <= ud_s1;
			neg_s[0]  <= neg_s1;
			if (ovf_s[NS])
				quot_sf <= neg_s[NS] ? -vpv_pkg::S64_MAX : vpv_pkg::S64_MAX;
			else
				quot_sf <= neg_s[NS] ? -q_full : q_full;
		end
	end

	for (genvar k = 0; k < NS; k++) begin : g_step
		logic [64:0] cand;
		logic        ge;

		always_comb begin
			cand = {rem_s[k], work_s[k][NS-1]};
			ge   = (cand >= {1'b0, ud_s[k]});
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_s[k+1] <= '0;
			else if (en)
				ctl_s[k+1] <= ctl_s[k];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1]  <= ge ? 64'(cand - {1'b0, ud_s[k]}) : cand[63:0];
				work_s[k+1] <= {work_s[k][NS-2:0], ge};
				ud_s[k+1]   <= ud_s[k];
				neg_s[k+1]  <= neg_s[k];
				ovf_s[k+1]  <= ovf_s[k];
			end
		end
	end

	assign ctl_out = ctl_sf;
	assign quot    = quot_sf;

endmodule

// ===== rtl/vpv_viewport.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vpv_viewport
// Maps normalized coordinates to the viewport and depth range, four stages.
// ----------------------------------------------------------------------------
module vpv_viewport #(
	parameter int FRAC_BITS = vpv_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               en,
	input  vpv_pkg::vp_cfg_t   cfg,
	input  vpv_pkg::ctl_t      ctl_in,
	input  logic signed [63:0] ndc_x,
	input  logic signed [63:0] ndc_y,
	input  logic signed [63:0] ndc_z,
	output vpv_pkg::ctl_t      ctl_out,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] screen_depth
);

	localparam logic signed [63:0] ONE_C = 64'sd1 <<< FRAC_BITS;

	vpv_pkg::ctl_t      ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [63:0] xo_s1, yo_s1, zo_s1;
	logic signed [17:0] dz_s1;
	logic signed [80:0] px_s2, py_s2;
	logic signed [81:0] pz_s2;
	logic signed [63:0] sx_s3, sy_s3, sz_s3;
	logic signed [31:0] fx_s4, fy_s4, fz_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else if (en) begin
			ctl_s1 <= ctl_in;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			xo_s1 <= vpv_pkg::sat_add64(ndc_x, ONE_C);
			yo_s1 <= vpv_pkg::sat_add64(ONE_C, -ndc_y);
			zo_s1 <= ndc_z;
			dz_s1 <= $signed({1'b0, cfg.far}) - $signed({1'b0, cfg.near});

			px_s2 <= 81'(xo_s1) * 81'($signed({1'b0, cfg.width}));
			py_s2 <= 81'(yo_s1) * 81'($signed({1'b0, cfg.height}));
			pz_s2 <= 82'(zo_s1) * 82'(dz_s1);

			// floor halving / rescale of the saturated products
			sx_s3 <= vpv_pkg::sat64({px_s2[80], px_s2}) >>> 1;
			sy_s3 <= vpv_pkg::sat64({py_s2[80], py_s2}) >>> 1;
			sz_s3 <= vpv_pkg::sat64(pz_s2) >>> FRAC_BITS;

			if (ctl_s3.w_zero) begin
				fx_s4 <= '0;
				fy_s4 <= '0;
				fz_s4 <= '0;
			end else begin
				fx_s4 <= vpv_pkg::sat32({sx_s3[63], sx_s3} + {{33{cfg.left[31]}}, cfg.left});
				fy_s4 <= vpv_pkg::sat32({sy_s3[63], sy_s3} + {{33{cfg.top[31]}}, cfg.top});
				fz_s4 <= vpv_pkg::sat32({sz_s3[63], sz_s3} + {48'd0, cfg.near});
			end
		end
	end

	assign ctl_out      = ctl_s4;
	assign screen_x     = fx_s4;
	assign screen_y     = fy_s4;
	assign screen_depth = fz_s4;

endmodule

// ===== rtl/vertex_project_to_viewport.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vertex_project_to_viewport
// Projects points through a stored 4x4 matrix onto the viewport.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): kind 0 writes matrix coefficient
// coef_index with coef_value and makes no result; kind 1 projects
// (point_x, point_y, point_z, 1) and makes one result item.
// Output channel (out_valid / out_stall): screen_x, screen_y, screen_depth,
// w_zero. Screen values are signed fixed point with FRAC_BITS fraction bits.
// An APB port sets the viewport left, top, width, height and the depth range;
// write it only while no item is in flight.
// A point passes the matrix stages, the three dividers side by side and the
// viewport stages; each divider takes one quotient bit per stage, 63 stages.
// Throughput is one item per clock while the output is not stalled.
// A stalled result holds in the output register; the whole pipeline then
// holds and in_stall is raised until the result is taken.
// Reset empties the pipeline, loads the identity matrix and the default
// viewport (1280 x 720, depth 0 to 1.0).
// ----------------------------------------------------------------------------
`include "vertex_project_to_viewport_macros.svh"

module vertex_project_to_viewport #(
	parameter int FRAC_BITS = vpv_pkg::FRAC_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               kind,
	input  logic [3:0]         coef_index,
	input  logic signed [31:0] coef_value,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] screen_x,
	output logic signed [31:0] screen_y,
	output logic signed [31:0] screen_depth,
	output logic               w_zero,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	logic signed [31:0] left_q, top_q;
	logic [15:0]        width_q, height_q;
	logic [16:0]        near_q, far_q;
	logic               wr_en;
	vpv_pkg::vp_cfg_t   cfg;

	logic               en, accept;
	vpv_pkg::ctl_t      mm_ctl, div_ctl, vp_ctl;
	logic signed [63:0] clip_x, clip_y, clip_z, clip_w;
	logic signed [63:0] ndc_x, ndc_y, ndc_z;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q   <= '0;
			top_q    <= '0;
			width_q  <= 16'd1280;
			height_q <= 16'd720;
			near_q   <= '0;
			far_q    <= 17'h10000;
		end else if (wr_en) begin
			case (vpv_pkg::reg_idx_t'(paddr[4:2]))
				vpv_pkg::REG_LEFT:   left_q   <= pwdata;
				vpv_pkg::REG_TOP:    top_q    <= pwdata;
				vpv_pkg::REG_WIDTH:  width_q  <= pwdata[15:0];
				vpv_pkg::REG_HEIGHT: height_q <= pwdata[15:0];
				vpv_pkg::REG_NEAR:   near_q   <= pwdata[16:0];
				vpv_pkg::REG_FAR:    far_q    <= pwdata[16:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (vpv_pkg::reg_idx_t'(paddr[4:2]))
			vpv_pkg::REG_LEFT:   prdata = left_q;
			vpv_pkg::REG_TOP:    prdata = top_q;
			vpv_pkg::REG_WIDTH:  prdata = {16'd0, width_q};
			vpv_pkg::REG_HEIGHT: prdata = {16'd0, height_q};
			vpv_pkg::REG_NEAR:   prdata = {15'd0, near_q};
			vpv_pkg::REG_FAR:    prdata = {15'd0, far_q};
			default:             prdata = '0;
		endcase
	end

	assign cfg = '{left: left_q, top: top_q, width: width_q, height: height_q,
		near: near_q, far: far_q};

	// whole pipeline advances together unless the output item is held
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;
	assign accept   = in_valid && en;

	vpv_matmul #(.FRAC_BITS(FRAC_BITS)) u_mm (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (en),
		.load       (accept && !kind),
		.proj       (accept && kind),
		.coef_index (coef_index),
		.coef_value (coef_value),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.ctl_out    (mm_ctl),
		.clip_x     (clip_x),
		.clip_y     (clip_y),
		.clip_z     (clip_z),
		.clip_w     (clip_w)
	);

	vpv_div #(.FRAC_BITS(FRAC_BITS)) u_div_x (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (mm_ctl),
		.num     (clip_x),
		.den     (clip_w),
		.ctl_out (div_ctl),
		.quot    (ndc_x)
	);

	vpv_div #(.FRAC_BITS(FRAC_BITS)) u_div_y (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (mm_ctl),
		.num     (clip_y),
		.den     (clip_w),
		.ctl_out (),
		.quot    (ndc_y)
	);

	vpv_div #(.FRAC_BITS(FRAC_BITS)) u_div_z (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.ctl_in  (mm_ctl),
		.num     (clip_z),
		.den     (clip_w),
		.ctl_out (),
		.quot    (ndc_z)
	);

	vpv_viewport #(.FRAC_BITS(FRAC_BITS)) u_vp (
		.clk          (clk),
		.arst_n       (arst_n),
		.en           (en),
		.cfg          (cfg),
		.ctl_in       (div_ctl),
		.ndc_x        (ndc_x),
		.ndc_y        (ndc_y),
		.ndc_z        (ndc_z),
		.ctl_out      (vp_ctl),
		.screen_x     (screen_x),
		.screen_y     (screen_y),
		.screen_depth (screen_depth)
	);

	assign out_valid = vp_ctl.valid;
	assign w_zero    = vp_ctl.w_zero;

	`VPV_CHECK_NOW(a_wzero_clears, out_valid && w_zero,
		screen_x == '0 && screen_y == '0 && screen_depth == '0, "w_zero item not zeroed")
	`VPV_CHECK_NEXT(a_width_write, wr_en && (paddr[4:2] == 3'(vpv_pkg::REG_WIDTH)),
		width_q == $past(pwdata[15:0]), "viewport width write lost")
	`VPV_CHECK_NOW(a_ndc_no_min, div_ctl.valid && !div_ctl.w_zero,
		ndc_x != vpv_pkg::S64_MIN && ndc_y != vpv_pkg::S64_MIN && ndc_z != vpv_pkg::S64_MIN,
		"divider produced the most negative value")

endmodule

// ===== test/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the vertex projector: predicts every projected point
// from its own matrix and viewport copy and checks each result in order.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int FB = 16;
	localparam logic signed [63:0] ONE = 64'sd1 <<< FB;
	localparam logic KIND_LOAD = 1'b0;
	localparam logic KIND_PROJ = 1'b1;
	localparam int LATENCY = 74;
	localparam longint CYCLE_LIMIT = 2000000;

	typedef struct packed {
		logic signed [31:0] sx;
		logic signed [31:0] sy;
		logic signed [31:0] sd;
		logic               wz;
	} screen_t;

	logic clk, arst_n;
	logic in_valid, in_stall, kind;
	logic [3:0] coef_index;
	logic signed [31:0] coef_value, point_x, point_y, point_z;
	logic out_valid, out_stall;
	logic signed [31:0] screen_x, screen_y, screen_depth;
	logic w_zero;
	logic psel, penable, pwrite, pready;
	logic [4:0] paddr;
	logic [31:0] pwdata, prdata;

	vertex_project_to_viewport dut (.*);

	// model state
	logic signed [31:0] mat [16];
	logic signed [63:0] m_left, m_top, m_width, m_height, m_near, m_far;
	screen_t screen_q[$];
	int errors = 0;
	longint cycles = 0;
	int hold_off = 0;
	bit rx_idle_en = 1;

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic logic signed [63:0] sadd(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [64:0] s;
		s = a + b;
		if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return vpv_pkg::S64_MAX;
		if (s < -65'sh0_8000_0000_0000_0000) return vpv_pkg::S64_MIN;
		return s[63:0];
	endfunction

	function automatic logic signed [63:0] smul(logic signed [63:0] a, logic signed [63:0] b);
		logic signed [127:0] p;
		p = 128'(a) * 128'(b);
		if (p > 128'sh7FFF_FFFF_FFFF_FFFF) return vpv_pkg::S64_MAX;
		if (p < -128'sh8000_0000_0000_0000) return vpv_pkg::S64_MIN;
		return p[63:0];
	endfunction

	function automatic logic signed [63:0] fdiv(logic signed [63:0] n, logic signed [63:0] d);
		logic [127:0] un, ud, q;
		logic neg;
		un = n < 0 ? -128'(n) : 128'(n);
		ud = d < 0 ? -128'(d) : 128'(d);
		neg = (n < 0) != (d < 0);
		q = (un << FB) / ud;
		if (q > 128'h7FFF_FFFF_FFFF_FFFF) q = 128'h7FFF_FFFF_FFFF_FFFF;
		return neg ? -$signed(q[63:0]) : $signed(q[63:0]);
	endfunction

	function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
		if (v > 64'sh7FFF_FFFF) return vpv_pkg::S32_MAX;
		if (v < -64'sh8000_0000) return vpv_pkg::S32_MIN;
		return v[31:0];
	endfunction

	function automatic screen_t project(logic signed [31:0] x, logic signed [31:0] y,
		logic signed [31:0] z);
		logic signed [63:0] p [3];
		logic signed [63:0] clip [4];
		logic signed [63:0] ndc [3];
		logic signed [63:0] acc, sx, sy, sz;
		screen_t r;
		p[0] = 64'(x); p[1] = 64'(y); p[2] = 64'(z);
		for (int c = 0; c < 4; c++) begin
			acc = '0;
			for (int k = 0; k < 3; k++) acc = sadd(acc, smul(p[k], 64'(mat[k*4+c])));
			clip[c] = sadd(acc, smul(64'(mat[12+c]), ONE));
		end
		if (clip[3] == 0) return '{0, 0, 0, 1'b1};
		for (int c = 0; c < 3; c++) ndc[c] = fdiv(clip[c], clip[3]);
		sx = smul(sadd(ndc[0], ONE), m_width) >>> 1;
		sy = smul(sadd(ONE, -ndc[1]), m_height) >>> 1;
		sz = smul(ndc[2], m_far - m_near) >>> FB;
		r.sx = clamp32(sadd(sx, m_left));
		r.sy = clamp32(sadd(sy, m_top));
		r.sd = clamp32(sadd(sz, m_near));
		r.wz = 1'b0;
		return r;
	endfunction

	task automatic apb_write(vpv_pkg::reg_idx_t idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1; penable <= 0; pwrite <= 1; paddr <= 5'(idx) << 2; pwdata <= val;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 0; penable <= 0; pwrite <= 0;
		case (idx)
			vpv_pkg::REG_LEFT:   m_left = 64'($signed(val));
			vpv_pkg::REG_TOP:    m_top = 64'($signed(val));
			vpv_pkg::REG_WIDTH:  m_width = 64'(val[15:0]);
			vpv_pkg::REG_HEIGHT: m_height = 64'(val[15:0]);
			vpv_pkg::REG_NEAR:   m_near = 64'(val[16:0]);
			vpv_pkg::REG_FAR:    m_far = 64'(val[16:0]);
			default: ;
		endcase
	endtask

	task automatic drain();
		in_valid <= 0;
		while (screen_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	// valid stays up between back-to-back items; it drops only for a gap or a drain
	task automatic send(logic k, logic [3:0] ci, logic [31:0] cv,
		logic [31:0] x, logic [31:0] y, logic [31:0] z, bit gaps = 1);
		int gap;
		gap = gaps && $urandom_range(3) == 0 ? $urandom_range(18) : 0;
		if (gap > 0) begin
			in_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1; kind <= k; coef_index <= ci; coef_value <= cv;
		point_x <= x; point_y <= y; point_z <= z;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (k == KIND_LOAD) mat[ci] = cv;
		else screen_q.push_back(project(x, y, z));
	endtask

	function automatic logic [31:0] rnd_coord();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(40)) - 20 <<< FB;
			default: return $signed($urandom_range(1 << 21)) - (1 << 20) <<< 4;
		endcase
	endfunction

	// receiver
	always @(posedge clk) begin
		if (out_valid && !out_stall) begin
			if (screen_q.size() == 0) begin
				$display("%0t: unexpected result %h %h %h %b", $time,
					screen_x, screen_y, screen_depth, w_zero);
				errors++;
			end else begin
				screen_t e;
				e = screen_q.pop_front();
				if (e.sx !== screen_x || e.sy !== screen_y || e.sd !== screen_depth ||
					e.wz !== w_zero) begin
					$display("%0t: mismatch exp %h %h %h %b got %h %h %h %b", $time,
						e.sx, e.sy, e.sd, e.wz, screen_x, screen_y, screen_depth, w_zero);
					errors++;
				end
			end
		end
	end

	// stall draw per item; long hold-off on request
	initial begin
		int n;
		out_stall = 0;
		@(posedge arst_n);
		forever begin
			if (hold_off > 0) begin
				out_stall <= 1;
				repeat (hold_off) @(posedge clk);
				hold_off = 0;
				out_stall <= 0;
			end
			n = rx_idle_en && $urandom_range(2) == 0 ? $urandom_range(18) : 0;
			if (n > 0) begin
				out_stall <= 1;
				repeat (n) @(posedge clk);
				out_stall <= 0;
			end
			@(posedge clk);
			while (!(out_valid && !out_stall)) @(posedge clk);
		end
	end

	task automatic test_directed();
		logic [31:0] ext [6] = '{32'h8000_0000, 32'h7FFF_FFFF, 0, 32'hFFFF_FFFF, 1, 32'h0001_0000};
		foreach (ext[i]) send(KIND_PROJ, 4'hF, 32'hFFFF_FFFF, ext[i], ext[(i+1)%6], ext[(i+2)%6]);
		send(KIND_LOAD, 4'd15, 0, 32'hFFFF_FFFF, 0, 0);          // w offset becomes zero
		send(KIND_PROJ, 4'd0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000);
		send(KIND_LOAD, 4'd11, 32'h0001_0000, 0, 0, 0);           // z term of w gets weight 1.0
		send(KIND_PROJ, 4'd0, 0, 32'h0001_0000, 32'h0002_0000, 32'h0004_0000);
		send(KIND_PROJ, 4'd0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 1);   // tiny z term in w
		send(KIND_LOAD, 4'd0, 32'h7FFF_FFFF, 0, 0, 0);
		send(KIND_LOAD, 4'd5, 32'h8000_0000, 0, 0, 0);
		send(KIND_PROJ, 4'd0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0000_0001);
		send(KIND_PROJ, 4'd0, 0, 32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF);
		drain();
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(5) == 0)
				send(KIND_LOAD, 4'($urandom), $urandom_range(1) ? $urandom :
					32'($signed($urandom_range(8)) - 4 <<< (FB - $urandom_range(3))),
					$urandom, $urandom, $urandom);
			else
				send(KIND_PROJ, 4'($urandom), $urandom, rnd_coord(), rnd_coord(),
					rnd_coord());
		end
		drain();
	endtask

	task automatic test_config(int setting);
		case (setting)
			0: begin
				apb_write(vpv_pkg::REG_LEFT, 32'h8000_0000);
				apb_write(vpv_pkg::REG_TOP, 32'h7FFF_FFFF);
				apb_write(vpv_pkg::REG_WIDTH, 32'h0000_FFFF);
				apb_write(vpv_pkg::REG_HEIGHT, 1);
				apb_write(vpv_pkg::REG_NEAR, 32'h0001_0000);
				apb_write(vpv_pkg::REG_FAR, 0);
			end
			1: begin
				apb_write(vpv_pkg::REG_LEFT, 32'h7FFF_FFFF);
				apb_write(vpv_pkg::REG_TOP, 32'h8000_0000);
				apb_write(vpv_pkg::REG_WIDTH, 0);
				apb_write(vpv_pkg::REG_HEIGHT, 0);
				apb_write(vpv_pkg::REG_NEAR, 32'h0001_FFFF);
				apb_write(vpv_pkg::REG_FAR, 32'h0001_FFFF);
			end
			default: begin
				apb_write(vpv_pkg::REG_LEFT, $urandom);
				apb_write(vpv_pkg::REG_TOP, $urandom);
				apb_write(vpv_pkg::REG_WIDTH, $urandom);
				apb_write(vpv_pkg::REG_HEIGHT, $urandom);
				apb_write(vpv_pkg::REG_NEAR, $urandom);
				apb_write(vpv_pkg::REG_FAR, $urandom);
			end
		endcase
	endtask

	task automatic test_backpressure();
		hold_off = 300;
		rx_idle_en = 0;
		for (int i = 0; i < 120; i++)
			send(KIND_PROJ, 4'd0, 0, rnd_coord(), rnd_coord(), rnd_coord(), 0);
		rx_idle_en = 1;
		drain();
	endtask

	initial begin
		in_valid = 0; kind = 0; coef_index = 0; coef_value = 0;
		point_x = 0; point_y = 0; point_z = 0;
		psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
		for (int i = 0; i < 16; i++) mat[i] = (i % 5 == 0) ? 32'(ONE) : '0;
		m_left = 0; m_top = 0; m_width = 1280; m_height = 720; m_near = 0; m_far = ONE;
		arst_n = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		test_random(150);
		test_directed();
		test_config(0);
		test_random(150);
		test_config(1);
		test_random(100);
		test_config(2);
		test_backpressure();
		test_config(2);
		test_random(300);
		if (errors == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
